[sv/stp_pkg.sv]
package stp_pkg;

    // Input payload layout inside the slave tdata bus.
    localparam int ID_W     = 32;
    localparam int COORD_W  = 31;
    localparam int ONSET_W  = 16;
    localparam int BOOT_W   = 16;
    localparam int RAD_W    = 32;
    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 40;
    localparam int BIDX_W   = 6;
    localparam int TAU_W    = 32;
    localparam int CNT_W    = 32;
    localparam int SQ_W     = 64;
    localparam int D2_W     = 63;
    localparam int PROD_W   = 64;
    localparam int DIV_STEPS = 32;
    localparam int DCNT_W   = 5;

    localparam int ID_LO    = 0;
    localparam int X_LO     = 32;
    localparam int Y_LO     = 63;
    localparam int ONSET_LO = 94;
    localparam int KNOWN_LO = 110;
    localparam int BOOT_LO  = 111;
    localparam int INNER_LO = 127;
    localparam int OUTER_LO = 159;

    // Request kinds on the slave tuser bit.
    localparam logic REQ_POINT = 1'b0;
    localparam logic REQ_BAND  = 1'b1;

    // Configuration register indexes and reset values.
    localparam logic [0:0] REG_SERIAL_INTERVAL = 1'd0;
    localparam logic [0:0] REG_BOOT_CHECK      = 1'd1;
    localparam logic [ONSET_W-1:0] SERIAL_INTERVAL_RST = 16'd7;

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_WALK,
        S_DRAIN,
        S_PROD,
        S_SAT,
        S_DIV,
        S_PUT,
        S_OUT,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_en;
        logic walk_init;
        logic walk_step;
        logic band_first;
        logic band_next;
        logic prod;
        logic div_init;
        logic div_step;
        logic out_load;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic load_last;
        logic has_pairs;
        logic walk_last;
        logic pipe_busy;
        logic no_bands;
        logic band_last;
        logic div_last;
        logic out_taken;
    } t_sts;

endpackage

[sv/stp_ctrl.sv]
module stp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stp_pkg::t_sts  i_sts,
    output stp_pkg::t_cmd  o_cmd
);

    stp_pkg::t_state r_state;
    stp_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stp_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            stp_pkg::S_LOAD: begin
                if (i_sts.load_last) n_state = stp_pkg::S_START;
            end
            stp_pkg::S_START: begin
                n_state = i_sts.has_pairs ? stp_pkg::S_WALK : stp_pkg::S_DRAIN;
            end
            stp_pkg::S_WALK: begin
                if (i_sts.walk_last) n_state = stp_pkg::S_DRAIN;
            end
            stp_pkg::S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = i_sts.no_bands ? stp_pkg::S_FINISH : stp_pkg::S_PROD;
                end
            end
            stp_pkg::S_PROD: n_state = stp_pkg::S_SAT;
            stp_pkg::S_SAT:  n_state = stp_pkg::S_DIV;
            stp_pkg::S_DIV: begin
                if (i_sts.div_last) n_state = stp_pkg::S_PUT;
            end
            stp_pkg::S_PUT: n_state = stp_pkg::S_OUT;
            stp_pkg::S_OUT: begin
                if (i_sts.out_taken) begin
                    n_state = i_sts.band_last ? stp_pkg::S_FINISH : stp_pkg::S_PROD;
                end
            end
            stp_pkg::S_FINISH: n_state = stp_pkg::S_LOAD;
            default: n_state = stp_pkg::S_LOAD;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            stp_pkg::S_LOAD:  o_cmd.load_en = 1'b1;
            stp_pkg::S_START: o_cmd.walk_init = 1'b1;
            stp_pkg::S_WALK:  o_cmd.walk_step = 1'b1;
            stp_pkg::S_DRAIN: o_cmd.band_first = ~i_sts.pipe_busy;
            stp_pkg::S_PROD:  o_cmd.prod = 1'b1;
            stp_pkg::S_SAT:   o_cmd.div_init = 1'b1;
            stp_pkg::S_DIV:   o_cmd.div_step = 1'b1;
            stp_pkg::S_PUT:   o_cmd.out_load = 1'b1;
            stp_pkg::S_OUT:   o_cmd.band_next = i_sts.out_taken & ~i_sts.band_last;
            stp_pkg::S_FINISH: o_cmd.finish = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

[sv/stp_dp.sv]
module stp_dp #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_BANDS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  stp_pkg::t_cmd                      i_cmd,
    output stp_pkg::t_sts                      o_sts,
    input  logic                               i_cfg_valid,
    input  logic [0:0]                         i_cfg_index,
    input  logic [stp_pkg::ONSET_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [stp_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  logic                               i_in_kind,
    input  logic                               i_in_last,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [stp_pkg::OUT_TDATA_W-1:0]    o_out_data,
    output logic                               o_out_inv,
    output logic                               o_out_last
);

    localparam int PW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int KW  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int BCW = $clog2(MAX_BANDS + 1);

    typedef struct packed {
        logic [stp_pkg::ID_W-1:0]    id;
        logic [stp_pkg::COORD_W-1:0] x;
        logic [stp_pkg::COORD_W-1:0] y;
        logic                        known;
        logic [stp_pkg::ONSET_W-1:0] onset;
        logic [stp_pkg::BOOT_W-1:0]  boot;
    } t_point;

    // Configuration registers.
    logic [stp_pkg::ONSET_W-1:0] r_si;
    logic                        r_boot_chk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_si       <= stp_pkg::SERIAL_INTERVAL_RST;
            r_boot_chk <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                stp_pkg::REG_SERIAL_INTERVAL: r_si <= i_cfg_data;
                stp_pkg::REG_BOOT_CHECK:      r_boot_chk <= i_cfg_data[0];
                default: r_si <= r_si;
            endcase
        end
    end

    // Load side: counts and point store writes.
    logic          in_acc;
    logic [CW-1:0] r_points;
    logic [BCW-1:0] r_bands;
    t_point        wr_pt;
    logic          pt_wr;
    logic          bd_wr;

    assign o_in_ready = i_cmd.load_en;
    assign in_acc     = i_in_valid & i_cmd.load_en;
    assign pt_wr = in_acc && (i_in_kind == stp_pkg::REQ_POINT)
                   && (r_points < CW'(MAX_POINTS));
    assign bd_wr = in_acc && (i_in_kind == stp_pkg::REQ_BAND)
                   && (r_bands < BCW'(MAX_BANDS));

    assign wr_pt.id    = i_in_data[stp_pkg::ID_LO +: stp_pkg::ID_W];
    assign wr_pt.x     = i_in_data[stp_pkg::X_LO +: stp_pkg::COORD_W];
    assign wr_pt.y     = i_in_data[stp_pkg::Y_LO +: stp_pkg::COORD_W];
    assign wr_pt.onset = i_in_data[stp_pkg::ONSET_LO +: stp_pkg::ONSET_W];
    assign wr_pt.known = i_in_data[stp_pkg::KNOWN_LO];
    assign wr_pt.boot  = i_in_data[stp_pkg::BOOT_LO +: stp_pkg::BOOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= '0;
            r_bands  <= '0;
        end else if (i_cmd.finish) begin
            r_points <= '0;
            r_bands  <= '0;
        end else begin
            if (pt_wr) r_points <= r_points + CW'(1);
            if (bd_wr) r_bands  <= r_bands + BCW'(1);
        end
    end

    // Point memory: one write port, two registered read ports.
    t_point         r_mem [MAX_POINTS];
    t_point         r_rd_a;
    t_point         r_rd_b;
    logic [PW-1:0]  r_pi;
    logic [PW-1:0]  r_pj;

    always_ff @(posedge i_clk) begin
        if (pt_wr) r_mem[r_points[PW-1:0]] <= wr_pt;
        r_rd_a <= r_mem[r_pi];
        r_rd_b <= r_mem[r_pj];
    end

    // Band radius staging; the squares are written in the cycle after the band is accepted.
    logic           r_bw;
    logic [KW-1:0]  r_bw_idx;
    logic [stp_pkg::RAD_W-1:0] r_bw_ri;
    logic [stp_pkg::RAD_W-1:0] r_bw_ro;
    logic [stp_pkg::SQ_W-1:0]  r_in_sq  [MAX_BANDS];
    logic [stp_pkg::SQ_W-1:0]  r_out_sq [MAX_BANDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw <= 1'b0;
        end else begin
            r_bw <= bd_wr;
        end
        r_bw_idx <= r_bands[KW-1:0];
        r_bw_ri  <= i_in_data[stp_pkg::INNER_LO +: stp_pkg::RAD_W];
        r_bw_ro  <= i_in_data[stp_pkg::OUTER_LO +: stp_pkg::RAD_W];
        if (r_bw) begin
            r_in_sq[r_bw_idx]  <= r_bw_ri * r_bw_ri;
            r_out_sq[r_bw_idx] <= r_bw_ro * r_bw_ro;
        end
    end

    // Pair walk address counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_pi <= PW'(1);
            r_pj <= '0;
        end else if (i_cmd.walk_step) begin
            if (r_pj == r_pi - PW'(1)) begin
                r_pi <= r_pi + PW'(1);
                r_pj <= '0;
            end else begin
                r_pj <= r_pj + PW'(1);
            end
        end
    end

    // Pair pipeline: read, qualify, square, sum.
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_rel2, r_rel3, r_rel4;
    logic [stp_pkg::COORD_W-1:0] r_dx, r_dy;
    logic [2*stp_pkg::COORD_W-1:0] r_dx2, r_dy2;
    logic [stp_pkg::D2_W-1:0] r_d2;
    logic                    skip;
    logic                    related;
    logic [stp_pkg::ONSET_W-1:0] odiff;
    logic signed [stp_pkg::COORD_W:0] dxs, dys;
    logic [stp_pkg::COORD_W:0] dxa, dya;

    always_comb begin
        skip = (r_boot_chk && (r_rd_a.boot == r_rd_b.boot)) || (r_rd_a.id == r_rd_b.id);
        odiff = (r_rd_a.onset > r_rd_b.onset) ? r_rd_a.onset - r_rd_b.onset
                                              : r_rd_b.onset - r_rd_a.onset;
        related = r_rd_a.known && r_rd_b.known && (odiff <= r_si);
        dxs = $signed({r_rd_a.x[stp_pkg::COORD_W-1], r_rd_a.x})
              - $signed({r_rd_b.x[stp_pkg::COORD_W-1], r_rd_b.x});
        dys = $signed({r_rd_a.y[stp_pkg::COORD_W-1], r_rd_a.y})
              - $signed({r_rd_b.y[stp_pkg::COORD_W-1], r_rd_b.y});
        dxa = dxs[stp_pkg::COORD_W] ? $unsigned(-dxs) : $unsigned(dxs);
        dya = dys[stp_pkg::COORD_W] ? $unsigned(-dys) : $unsigned(dys);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.walk_step;
            r_v2 <= r_v1 & ~skip;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_rel2 <= related;
        r_dx   <= dxa[stp_pkg::COORD_W-1:0];
        r_dy   <= dya[stp_pkg::COORD_W-1:0];
        r_rel3 <= r_rel2;
        r_dx2  <= r_dx * r_dx;
        r_dy2  <= r_dy * r_dy;
        r_rel4 <= r_rel3;
        r_d2   <= stp_pkg::D2_W'(r_dx2) + stp_pkg::D2_W'(r_dy2);
    end

    // Overall counters and one counting lane per band.
    logic [stp_pkg::CNT_W-1:0] r_onum, r_oden;
    logic [stp_pkg::CNT_W-1:0] r_bnum [MAX_BANDS];
    logic [stp_pkg::CNT_W-1:0] r_bden [MAX_BANDS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_onum <= '0;
            r_oden <= '0;
        end else if (r_v4) begin
            r_oden <= r_oden + stp_pkg::CNT_W'(1);
            if (r_rel4) r_onum <= r_onum + stp_pkg::CNT_W'(1);
        end
    end

    for (genvar l = 0; l < MAX_BANDS; l++) begin : g_lane
        logic hit;
        assign hit = r_v4 && (BCW'(l) < r_bands)
                     && ({1'b0, r_d2} >= r_in_sq[l]) && ({1'b0, r_d2} < r_out_sq[l]);
        always_ff @(posedge i_clk) begin
            if (i_cmd.walk_init) begin
                r_bnum[l] <= '0;
                r_bden[l] <= '0;
            end else if (hit) begin
                r_bden[l] <= r_bden[l] + stp_pkg::CNT_W'(1);
                if (r_rel4) r_bnum[l] <= r_bnum[l] + stp_pkg::CNT_W'(1);
            end
        end
    end

    // Result: band counter, cross products and restoring divider.
    logic [KW-1:0]               r_k;
    logic [stp_pkg::PROD_W-1:0]  r_n, r_d, r_rem;
    logic                        r_bad, r_sat;
    logic [stp_pkg::TAU_W-1:0]   r_q, r_nlo;
    logic [stp_pkg::DCNT_W-1:0]  r_dcnt;
    logic [stp_pkg::PROD_W:0]    trial;
    logic                        tfit;

    assign trial = {r_rem, r_nlo[stp_pkg::TAU_W-1]};
    assign tfit  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (i_cmd.band_first) begin
            r_k <= '0;
        end else if (i_cmd.band_next) begin
            r_k <= r_k + KW'(1);
        end
        if (i_cmd.prod) begin
            r_n   <= r_bnum[r_k] * r_oden;
            r_d   <= r_bden[r_k] * r_onum;
            r_bad <= (r_bden[r_k] == '0) || (r_oden == '0) || (r_onum == '0);
        end
        if (i_cmd.div_init) begin
            r_sat  <= {16'b0, r_n} >= {r_d, 16'b0};
            r_rem  <= {16'b0, r_n[stp_pkg::PROD_W-1:16]};
            r_nlo  <= {r_n[15:0], 16'b0};
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= tfit ? stp_pkg::PROD_W'(trial - {1'b0, r_d})
                           : trial[stp_pkg::PROD_W-1:0];
            r_q    <= {r_q[stp_pkg::TAU_W-2:0], tfit};
            r_nlo  <= {r_nlo[stp_pkg::TAU_W-2:0], 1'b0};
            r_dcnt <= r_dcnt + stp_pkg::DCNT_W'(1);
        end
    end

    // Output register.
    logic [stp_pkg::TAU_W-1:0]  r_tau;
    logic [stp_pkg::BIDX_W-1:0] r_bidx;
    logic                       r_ovalid, r_oinv, r_olast;
    logic                       band_last;

    assign band_last = (BCW'(r_k) == r_bands - BCW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_tau   <= r_bad ? '0 : (r_sat ? '1 : r_q);
            r_oinv  <= r_bad;
            r_bidx  <= stp_pkg::BIDX_W'(r_k);
            r_olast <= band_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {2'b00, r_tau, r_bidx};
    assign o_out_inv   = r_oinv;
    assign o_out_last  = r_olast;

    // Status back to the controller.
    assign o_sts.load_last = in_acc & i_in_last;
    assign o_sts.has_pairs = r_points >= CW'(2);
    assign o_sts.walk_last = (CW'(r_pi) == r_points - CW'(1)) && (r_pj == r_pi - PW'(1));
    assign o_sts.pipe_busy = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_sts.no_bands  = (r_bands == '0);
    assign o_sts.band_last = band_last;
    assign o_sts.div_last  = (r_dcnt == stp_pkg::DCNT_W'(stp_pkg::DIV_STEPS - 1));
    assign o_sts.out_taken = r_ovalid & i_out_ready;

endmodule

[sv/spatial_tau_pair_counter_top.sv]
// Spatial tau pair counter. Case points (tuser 0) and distance bands (tuser 1)
// load at one transaction per cycle; the transaction with tlast set is stored
// like the rest and then starts the evaluation, during which the slave side
// holds tready low. The evaluation walks all unordered point pairs through a
// two-port point memory at one pair per cycle, and the pair pipeline then
// drains. Each band then needs its cross products and a 32 step restoring
// divider, and one result transaction is offered per band in load order,
// the next band starting once the current result is taken. Tau is unsigned
// Q16.16, saturated; invalid results carry tau zero and the tuser flag.
module spatial_tau_pair_counter_top #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_BANDS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [0:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // case_id[31:0], x_coord[62:32], y_coord[93:63], onset_day[109:94],
    // has_onset[110], boot_id[126:111], band_inner[158:127],
    // band_outer[190:159], zero fill[191].
    input  logic [191:0] s_axis_tdata,
    // req_type[0].
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // band_index[5:0], tau_value[37:6], zero fill[39:38].
    output logic [39:0]  m_axis_tdata,
    // tau_invalid[0].
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

    stp_pkg::t_cmd cmd;
    stp_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    stp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    stp_dp #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_BANDS  (MAX_BANDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_kind   (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_inv   (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule
